// ===== rtl/affm_pkg.sv =====
// Package for the 2D homogeneous transform builder.
// Holds the transform codes, fixed-point constants, the CORDIC arctangent
// table and the sideband type that rides along the pipeline.
`default_nettype none

package affm_pkg;

  typedef enum logic [1:0] {
    MODE_TRANSLATE = 2'd0,
    MODE_SCALE     = 2'd1,
    MODE_ROTATE    = 2'd2,
    MODE_REFLECT   = 2'd3
  } mode_t;

  localparam int XW = 34;
  localparam int ZW = 25;
  localparam int ATAN_LEN = 24;

  localparam logic [24:0] FULL_TURN = 25'd23592960;
  localparam logic [24:0] HALF_TURN = 25'd11796480;
  localparam logic [24:0] QUARTER_TURN = 25'd5898240;
  localparam logic [24:0] FOLD_LIMIT = 25'd17694720;

  localparam logic [14:0] HU_OFFSET = 15'd8235;
  localparam logic [25:0] RECIP = 26'd1457;
  localparam logic [14:0] MOD_BASE = 15'd45;

  localparam logic signed [XW-1:0] GAIN_Q30 = 34'sd652032874;
  localparam logic signed [XW-1:0] ROUND_Q30 = 34'sd8192;
  localparam logic signed [31:0] ONE_Q16 = 32'sd65536;

  typedef struct packed {
    mode_t              mode;
    logic               neg;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
  } side_t;

  function automatic logic signed [ZW-1:0] atan_q16(input int unsigned idx);
    logic signed [ZW-1:0] a;
    case (idx)
      0: a = 25'sd2949120;
      1: a = 25'sd1740967;
      2: a = 25'sd919879;
      3: a = 25'sd466945;
      4: a = 25'sd234379;
      5: a = 25'sd117304;
      6: a = 25'sd58666;
      7: a = 25'sd29335;
      8: a = 25'sd14668;
      9: a = 25'sd7334;
      10: a = 25'sd3667;
      11: a = 25'sd1833;
      12: a = 25'sd917;
      13: a = 25'sd458;
      14: a = 25'sd229;
      15: a = 25'sd115;
      16: a = 25'sd57;
      17: a = 25'sd29;
      18: a = 25'sd14;
      19: a = 25'sd7;
      20: a = 25'sd4;
      21: a = 25'sd2;
      22: a = 25'sd1;
      default: a = 25'sd0;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/affm_ifs.sv =====
// Channel interfaces of the 2D homogeneous transform builder.
// Depends on nothing; payload widths follow the request and matrix fields.
`default_nettype none

interface affm_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         mode;
  logic signed [31:0] value_x;
  logic signed [31:0] value_y;

  modport source (output valid, output mode, output value_x, output value_y, input ready);
  modport sink (input valid, input mode, input value_x, input value_y, output ready);
endinterface

interface affm_mat_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] m00;
  logic signed [31:0] m01;
  logic signed [31:0] m02;
  logic signed [31:0] m10;
  logic signed [31:0] m11;
  logic signed [31:0] m12;

  modport source (output valid, output m00, output m01, output m02, output m10,
                  output m11, output m12, input ready);
  modport sink (input valid, input m00, input m01, input m02, input m10,
                input m11, input m12, output ready);
endinterface

`default_nettype wire

// ===== rtl/affm_cordic.sv =====
// Pipelined rotation-mode CORDIC, one register stage per iteration.
// Depends on affm_pkg for widths, the gain, the arctangent table and side_t.
`default_nettype none

module affm_cordic #(
  parameter int STAGES = 16
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              in_valid,
  input  wire logic signed [affm_pkg::ZW-1:0] in_z,
  input  wire affm_pkg::side_t             in_side,
  output logic                             in_ready,
  output logic                             out_valid,
  output logic signed [affm_pkg::XW-1:0]   out_x,
  output logic signed [affm_pkg::XW-1:0]   out_y,
  output affm_pkg::side_t                  out_side,
  input  wire                              out_ready
);
  import affm_pkg::*;

  logic                 v [STAGES];
  logic signed [XW-1:0] x [STAGES];
  logic signed [XW-1:0] y [STAGES];
  logic signed [ZW-1:0] z [STAGES];
  side_t                sd [STAGES];
  logic                 en [STAGES+1];

  assign en[STAGES] = out_ready;

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    localparam logic signed [ZW-1:0] ATAN = atan_q16(i);
    logic                 vi;
    logic signed [XW-1:0] xi;
    logic signed [XW-1:0] yi;
    logic signed [ZW-1:0] zi;
    side_t                si;

    if (i == 0) begin : g_first
      assign vi = in_valid;
      assign xi = GAIN_Q30;
      assign yi = '0;
      assign zi = in_z;
      assign si = in_side;
    end else begin : g_next
      assign vi = v[i-1];
      assign xi = x[i-1];
      assign yi = y[i-1];
      assign zi = z[i-1];
      assign si = sd[i-1];
    end

    assign en[i] = !v[i] || en[i+1];

    always_ff @(posedge clk) begin
      if (rst) begin
        v[i] <= 1'b0;
      end else if (en[i]) begin
        v[i] <= vi;
      end
      if (en[i]) begin
        sd[i] <= si;
        if (!zi[ZW-1]) begin
          x[i] <= xi - (yi >>> i);
          y[i] <= yi + (xi >>> i);
          z[i] <= zi - ATAN;
        end else begin
          x[i] <= xi + (yi >>> i);
          y[i] <= yi - (xi >>> i);
          z[i] <= zi + ATAN;
        end
      end
    end
  end

  assign in_ready = en[0];
  assign out_valid = v[STAGES-1];
  assign out_x = x[STAGES-1];
  assign out_y = y[STAGES-1];
  assign out_side = sd[STAGES-1];

endmodule

`default_nettype wire

// ===== rtl/affine_2d_matrix_builder_unit.sv =====
// Top level of the 2D homogeneous transform builder.
// Depends on affm_pkg, the channel interfaces and affm_cordic.
//
// A request transaction carries a transform code (translate, scale, rotate,
// reflect) and two signed Q16.16 values; a matrix transaction returns the top
// two rows of the 3x3 homogeneous matrix in Q16.16, the bottom row being
// 0 0 1. Rotate and reflect take value_x as an angle in degrees.
// From request to matrix, three stages reduce the angle modulo 360 and fold
// it into [-90, 90], one stage per CORDIC iteration follows, and the output
// register rounds and assembles the entries. One request is taken every
// cycle while the pipeline is not stalled.
// When the receiver stalls, the output register holds its transaction and
// each stage advances only into an empty or moving successor, so bubbles
// close up and requests keep being taken until the pipeline is full.
// Synchronous reset empties the pipeline; no transaction is in flight after.
`default_nettype none

module affine_2d_matrix_builder_unit #(
  parameter int CORDIC_STAGES = 16
) (
  input wire          clk,
  input wire          rst,
  affm_req_if.sink    req,
  affm_mat_if.source  mat
);
  import affm_pkg::*;

  localparam int NSTG = (CORDIC_STAGES > ATAN_LEN) ? ATAN_LEN : CORDIC_STAGES;

  logic        s1_v, s2_v, s3_v;
  logic        s1_en, s2_en, s3_en, out_en;
  side_t       in_side, s1_side, s2_side, s3_side;

  logic signed [32:0] ang;
  logic [14:0]        hu;
  logic [25:0]        qp;
  logic [14:0]        s1_hu;
  logic [8:0]         s1_q;
  logic [18:0]        s1_low;

  logic [14:0]        prod;
  logic signed [15:0] rem;
  logic signed [15:0] remc;
  logic [24:0]        s2_z;

  logic signed [ZW-1:0] zf;
  logic                 negf;
  logic signed [ZW-1:0] s3_z;

  logic                 cd_ready, cd_valid;
  logic signed [XW-1:0] cd_x, cd_y;
  side_t                cd_side;

  logic signed [XW-1:0] rx, ry;
  logic signed [31:0]   cq, sq, c, s;
  logic signed [31:0]   m00_next, m01_next, m02_next, m10_next, m11_next, m12_next;
  logic                 o_valid;

  assign out_en = !o_valid || mat.ready;
  assign s3_en = !s3_v || cd_ready;
  assign s2_en = !s2_v || s3_en;
  assign s1_en = !s1_v || s2_en;
  assign req.ready = s1_en;

  always_comb begin
    in_side.mode = mode_t'(req.mode);
    in_side.neg = 1'b0;
    in_side.vx = req.value_x;
    in_side.vy = req.value_y;
    if (mode_t'(req.mode) == MODE_REFLECT) begin
      ang = {req.value_x, 1'b0};
    end else begin
      ang = {req.value_x[31], req.value_x};
    end
    hu = {ang[32], ang[32:19]} + HU_OFFSET;
    qp = {11'b0, hu} * RECIP;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (s1_en) begin
      s1_v <= req.valid;
    end
    if (s1_en) begin
      s1_side <= in_side;
      s1_hu <= hu;
      s1_q <= qp[24:16];
      s1_low <= ang[18:0];
    end
  end

  always_comb begin
    prod = {6'b0, s1_q} * MOD_BASE;
    rem = $signed({1'b0, s1_hu}) - $signed({1'b0, prod});
    remc = rem[15] ? rem + $signed({1'b0, MOD_BASE}) : rem;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else if (s2_en) begin
      s2_v <= s1_v;
    end
    if (s2_en) begin
      s2_side <= s1_side;
      s2_z <= {remc[5:0], s1_low};
    end
  end

  always_comb begin
    if (s2_z <= QUARTER_TURN) begin
      zf = $signed(s2_z);
      negf = 1'b0;
    end else if (s2_z < FOLD_LIMIT) begin
      zf = $signed(s2_z - HALF_TURN);
      negf = 1'b1;
    end else begin
      zf = $signed(s2_z - FULL_TURN);
      negf = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_v <= 1'b0;
    end else if (s3_en) begin
      s3_v <= s2_v;
    end
    if (s3_en) begin
      s3_side <= '{mode: s2_side.mode, neg: negf, vx: s2_side.vx, vy: s2_side.vy};
      s3_z <= zf;
    end
  end

  affm_cordic #(
    .STAGES(NSTG)
  ) u_cordic (
    .clk(clk),
    .rst(rst),
    .in_valid(s3_v),
    .in_z(s3_z),
    .in_side(s3_side),
    .in_ready(cd_ready),
    .out_valid(cd_valid),
    .out_x(cd_x),
    .out_y(cd_y),
    .out_side(cd_side),
    .out_ready(out_en)
  );

  always_comb begin
    rx = cd_x + ROUND_Q30;
    ry = cd_y + ROUND_Q30;
    cq = {{12{rx[XW-1]}}, rx[XW-1:14]};
    sq = {{12{ry[XW-1]}}, ry[XW-1:14]};
    c = cd_side.neg ? -cq : cq;
    s = cd_side.neg ? -sq : sq;
    m00_next = ONE_Q16;
    m01_next = '0;
    m02_next = '0;
    m10_next = '0;
    m11_next = ONE_Q16;
    m12_next = '0;
    case (cd_side.mode)
      MODE_TRANSLATE: begin
        m02_next = cd_side.vx;
        m12_next = cd_side.vy;
      end
      MODE_SCALE: begin
        m00_next = cd_side.vx;
        m11_next = cd_side.vy;
      end
      MODE_ROTATE: begin
        m00_next = c;
        m01_next = -s;
        m10_next = s;
        m11_next = c;
      end
      default: begin
        m00_next = c;
        m01_next = s;
        m10_next = s;
        m11_next = -c;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (out_en) begin
      o_valid <= cd_valid;
    end
    if (out_en) begin
      mat.m00 <= m00_next;
      mat.m01 <= m01_next;
      mat.m02 <= m02_next;
      mat.m10 <= m10_next;
      mat.m11 <= m11_next;
      mat.m12 <= m12_next;
    end
  end

  assign mat.valid = o_valid;

endmodule

`default_nettype wire

// ===== rtl/affm_checker.sv =====
// Port-level checks for the 2D homogeneous transform builder.
// Depends on nothing; bound to affine_2d_matrix_builder_unit below.
`default_nettype none

module affm_checker (
  input wire                     clk,
  input wire                     rst,
  input wire                     req_valid,
  input wire                     req_ready,
  input wire                     mat_valid,
  input wire                     mat_ready,
  input wire logic signed [31:0] m00,
  input wire logic signed [31:0] m01,
  input wire logic signed [31:0] m10,
  input wire logic signed [31:0] m11
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !mat_valid)
    else $error("Matrix transaction shown right after reset.");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    mat_valid && !mat_ready |=> mat_valid && $stable(m00) && $stable(m01)
      && $stable(m10) && $stable(m11))
    else $error("Stalled matrix transaction changed.");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !mat_valid |-> req_ready)
    else $error("Request refused while the output register is empty.");

  a_matrix_shape: assert property (@(posedge clk) disable iff (rst)
    mat_valid |-> (m01 == 32'sd0 && m10 == 32'sd0)
      || (m00 == m11 && 32'(m01 + m10) == 32'sd0)
      || (32'(m00 + m11) == 32'sd0 && m01 == m10))
    else $error("Matrix is not a translation, scale, rotation or reflection.");

  a_req_used: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_ready |-> mat_valid)
    else $error("Request stalled while no matrix transaction waits.");

endmodule

bind affine_2d_matrix_builder_unit affm_checker u_affm_checker (
  .clk(clk),
  .rst(rst),
  .req_valid(req.valid),
  .req_ready(req.ready),
  .mat_valid(mat.valid),
  .mat_ready(mat.ready),
  .m00(mat.m00),
  .m01(mat.m01),
  .m10(mat.m10),
  .m11(mat.m11)
);

`default_nettype wire
